// ===== src/tws_pkg.sv =====
// Shared types and constants for the three-wire SPI register/FIFO master.
// Used by tws_front, tws_back and the top level; depends on nothing.
package tws_pkg;

  // Command opcodes carried in the input word
  localparam logic [1:0] OP_REG_WR   = 2'd0;
  localparam logic [1:0] OP_REG_RD   = 2'd1;
  localparam logic [1:0] OP_FIFO_WR  = 2'd2;
  // Undefined opcode: never starts a transfer
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Configuration register indexes
  localparam logic CFG_IDX_HALF = 1'b0;
  localparam logic CFG_IDX_GAP  = 1'b1;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
  localparam logic [7:0] FIFO_GAP_RESET    = 8'd10;

  // Address framing: read flag in bit 7 of the address byte
  localparam logic [6:0] ADDR_MASK = 7'h7f;
  localparam logic [7:0] READ_FLAG = 8'h80;

  // Last half-bit index: 32 halves for a register frame, 16 for a FIFO byte
  localparam logic [4:0] LAST_HALF_REG  = 5'd31;
  localparam logic [4:0] LAST_HALF_FIFO = 5'd15;

  // Depth of the queues on either side of the sequencer
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_HOLD,
    PH_RELEASE
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [6:0] reg_address;
    logic [7:0] write_byte;
    logic       sdio_in;
  } in_item_t;

  typedef struct packed {
    logic       reg_select_n;
    logic       fifo_select_n;
    logic       serial_clock;
    logic       sdio_out;
    logic       sdio_drive;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
  } out_item_t;

  // Classified tick as handed from front to back
  typedef struct packed {
    logic        start;    // a legal command is offered
    logic [1:0]  op;
    logic [15:0] frame;    // bits to shift out, MSB first
    logic        sdio_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] fifo_gap_ticks;
  } cfg_t;

endpackage

// ===== src/three_wire_spi_register_fifo_master_unit.sv =====
// Top level of the three-wire SPI master with register and FIFO selects.
// Holds the configuration registers and joins tws_front and tws_back; uses tws_pkg.
//
//   channel  ports                          word
//   input    in_push / in_full / in_item    one tick: command fields and sdio_in
//   result   out_pop / out_empty / out_item pin levels of that tick, read status
//   config   cfg_we / cfg_index / cfg_wdata half period (0), FIFO gap (1)
//
// One input word is taken every cycle while in_full is low; each gives one
// result word, which passes through the input queue and then the result
// queue to the out_ ports. The sequencer steps once a cycle while its input
// queue holds a word and the result queue has room.
// Reset (rst_n, synchronous) empties both queues and sets the sequencer idle.
// A stalled result side fills the result queue, then the input queue, then full.
module three_wire_spi_register_fifo_master_unit #(
  parameter int QUEUE_DEPTH = tws_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tws_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output tws_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  tws_pkg::cfg_t cfg_r;
  tws_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          deq;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= tws_pkg::HALF_PERIOD_RESET;
      cfg_r.fifo_gap_ticks    <= tws_pkg::FIFO_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tws_pkg::CFG_IDX_HALF: cfg_r.half_period_ticks <= cfg_wdata;
        tws_pkg::CFG_IDX_GAP:  cfg_r.fifo_gap_ticks    <= cfg_wdata;
        default:               cfg_r <= cfg_r;
      endcase
    end
  end

  tws_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .deq     (deq),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  tws_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .deq       (deq),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Never both selects low
  a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.reg_select_n || out_item.fifo_select_n))
    else $error("both selects low");

  // Idle word: selects high, clock low
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.busy_res) |->
      (out_item.reg_select_n && out_item.fifo_select_n && !out_item.serial_clock))
    else $error("pins not idle while not busy");

  // Line released only inside a register read
  a_turnaround: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.sdio_drive) |->
      (!out_item.reg_select_n && out_item.busy_res && !out_item.sdio_out))
    else $error("data line released outside a register read");

endmodule

// ===== src/tws_front.sv =====
// Front end: takes input words, decodes the command and builds the frame.
// Holds classified words in a short queue for tws_back; uses tws_pkg.
module tws_front #(
  parameter int DEPTH = tws_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tws_pkg::in_item_t  in_item,
  input  logic               deq,
  output logic               q_valid,
  output tws_pkg::cmd_t      q_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tws_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  tws_pkg::cmd_t   cls;
  logic            push, pop;

  // Classify the incoming word and pre-form the shift frame
  always_comb begin
    cls.start   = in_item.cmd_valid && (in_item.opcode != tws_pkg::OP_RESERVED);
    cls.op      = in_item.opcode;
    cls.sdio_in = in_item.sdio_in;
    unique case (in_item.opcode)
      tws_pkg::OP_REG_WR:
        cls.frame = {1'b0, in_item.reg_address & tws_pkg::ADDR_MASK, in_item.write_byte};
      tws_pkg::OP_REG_RD:
        cls.frame = {{1'b0, in_item.reg_address} | tws_pkg::READ_FLAG, 8'h00};
      default:
        cls.frame = {in_item.write_byte, 8'h00};
    endcase
  end

  assign in_full = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign push    = in_push && !in_full;
  assign pop     = deq && q_valid;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== src/tws_back.sv =====
// Back end: the pin sequencer, one tick per queued word, and the result queue.
// Takes classified words from tws_front and configuration from the top; uses tws_pkg.
module tws_back #(
  parameter int DEPTH = tws_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tws_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  tws_pkg::cmd_t      q_cmd,
  output logic               deq,
  output logic               out_empty,
  input  logic               out_pop,
  output tws_pkg::out_item_t out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer state
  tws_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]      bc_r, bc_nxt;
  logic [15:0]     shift_r, shift_nxt;
  logic [7:0]      in_shift_r, in_shift_nxt;
  logic [7:0]      td_r, td_nxt;
  logic [1:0]      op_r, op_nxt;
  logic            rd_done_r, rd_done_nxt;

  // State as seen during this tick, after a possible command start
  tws_pkg::phase_t ph;
  logic [1:0]      op;
  logic [15:0]     frame;
  logic [4:0]      bc;
  logic [7:0]      td;

  logic [7:0]      h;
  logic [8:0]      td_inc;
  logic            tick_end;
  logic            gap_end;
  logic            read_phase;
  logic [7:0]      stage_len;
  logic [4:0]      last_half;
  logic            step;

  tws_pkg::out_item_t res;

  // Result queue
  tws_pkg::out_item_t omem_r [DEPTH];
  logic [PW-1:0]      owr_r, owr_nxt;
  logic [PW-1:0]      ord_r, ord_nxt;
  logic [CW-1:0]      ocnt_r, ocnt_nxt;
  logic               opop;

  assign step = q_valid && (ocnt_r != CW'(DEPTH));
  assign deq  = step;

  // Start a command when idle
  always_comb begin
    ph    = phase_r;
    op    = op_r;
    frame = shift_r;
    bc    = bc_r;
    td    = td_r;
    if (phase_r == tws_pkg::PH_IDLE && q_cmd.start) begin
      ph    = tws_pkg::PH_SHIFT;
      op    = q_cmd.op;
      frame = q_cmd.frame;
      bc    = '0;
      td    = '0;
    end
  end

  assign h          = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
  assign td_inc     = {1'b0, td} + 9'd1;
  assign tick_end   = (td_inc >= {1'b0, h});
  assign stage_len  = (op == tws_pkg::OP_FIFO_WR) ? cfg.fifo_gap_ticks : h;
  assign gap_end    = (td_inc >= {1'b0, stage_len});
  assign read_phase = (op == tws_pkg::OP_REG_RD) && bc[4];
  assign last_half  = (op == tws_pkg::OP_FIFO_WR) ? tws_pkg::LAST_HALF_FIFO
                                                  : tws_pkg::LAST_HALF_REG;

  // Drive pin levels for this tick
  always_comb begin
    res.busy_res      = (ph != tws_pkg::PH_IDLE);
    res.reg_select_n  = !(res.busy_res && op != tws_pkg::OP_FIFO_WR);
    res.fifo_select_n = !(res.busy_res && op == tws_pkg::OP_FIFO_WR &&
                          ph != tws_pkg::PH_RELEASE);
    res.serial_clock  = 1'b0;
    res.sdio_out      = 1'b0;
    res.sdio_drive    = 1'b1;
    if (ph == tws_pkg::PH_SHIFT) begin
      res.serial_clock = bc[0];
      if (read_phase) begin
        res.sdio_drive = 1'b0;
      end else begin
        res.sdio_out = frame[4'd15 - bc[4:1]];
      end
    end
    res.read_byte  = in_shift_nxt;
    res.read_valid = rd_done_r;
  end

  // Next state of the sequencer
  always_comb begin
    phase_nxt    = ph;
    op_nxt       = op;
    shift_nxt    = frame;
    bc_nxt       = bc;
    td_nxt       = td;
    in_shift_nxt = in_shift_r;
    rd_done_nxt  = 1'b0;
    unique case (ph)
      tws_pkg::PH_SHIFT: begin
        if (read_phase && bc[0] && tick_end) begin
          in_shift_nxt = {in_shift_r[6:0], q_cmd.sdio_in};
        end
        if (tick_end) begin
          td_nxt = '0;
          if (bc >= last_half) begin
            bc_nxt = '0;
            if (op == tws_pkg::OP_REG_RD) begin
              phase_nxt   = tws_pkg::PH_IDLE;
              rd_done_nxt = 1'b1;
            end else if (op == tws_pkg::OP_FIFO_WR && cfg.fifo_gap_ticks == 8'd0) begin
              phase_nxt = tws_pkg::PH_IDLE;
            end else begin
              phase_nxt = tws_pkg::PH_HOLD;
            end
          end else begin
            bc_nxt = bc + 5'd1;
          end
        end else begin
          td_nxt = td_inc[7:0];
        end
      end
      tws_pkg::PH_HOLD, tws_pkg::PH_RELEASE: begin
        if (gap_end) begin
          td_nxt = '0;
          if (ph == tws_pkg::PH_HOLD && op == tws_pkg::OP_FIFO_WR &&
              cfg.fifo_gap_ticks != 8'd0) begin
            phase_nxt = tws_pkg::PH_RELEASE;
          end else begin
            phase_nxt = tws_pkg::PH_IDLE;
            bc_nxt    = '0;
          end
        end else begin
          td_nxt = td_inc[7:0];
        end
      end
      default: begin
        bc_nxt = bc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tws_pkg::PH_IDLE;
      bc_r       <= '0;
      shift_r    <= '0;
      in_shift_r <= '0;
      td_r       <= '0;
      op_r       <= '0;
      rd_done_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bc_r       <= bc_nxt;
      shift_r    <= shift_nxt;
      in_shift_r <= in_shift_nxt;
      td_r       <= td_nxt;
      op_r       <= op_nxt;
      rd_done_r  <= rd_done_nxt;
    end
  end

  // Result queue: push each tick's pin word, pop on request
  assign out_empty = (ocnt_r == '0);
  assign out_item  = omem_r[ord_r];
  assign opop      = out_pop && !out_empty;

  always_comb begin
    owr_nxt = owr_r;
    ord_nxt = ord_r;
    if (step) begin
      owr_nxt = (owr_r == PW'(DEPTH - 1)) ? '0 : owr_r + 1'b1;
    end
    if (opop) begin
      ord_nxt = (ord_r == PW'(DEPTH - 1)) ? '0 : ord_r + 1'b1;
    end
    ocnt_nxt = ocnt_r + CW'(step) - CW'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_nxt;
      ord_r  <= ord_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      omem_r[owr_r] <= res;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for three_wire_spi_register_fifo_master_unit: drives one tick word per
// handshake, predicts the pin levels of every tick and compares them; needs the DUT and tws_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned LONG_HOLD_CYCLES = 150;
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned WORDS_PER_PHASE  = 70;
  localparam int unsigned PRINT_CAP        = 30;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               cfg_idx;
    logic [7:0]         cfg_val;
    tws_pkg::in_item_t  word;
    int unsigned        count;
    bit                 typed;
    tws_pkg::out_item_t pins;
  } step_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  tws_pkg::in_item_t  in_item = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  tws_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [7:0]         cfg_wdata = 8'd0;

  three_wire_spi_register_fifo_master_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Sequencer mirror: configuration and state as the block should hold them
  logic [7:0]      half_ticks_cfg = tws_pkg::HALF_PERIOD_RESET;
  logic [7:0]      gap_ticks_cfg  = tws_pkg::FIFO_GAP_RESET;
  tws_pkg::phase_t sq_phase   = tws_pkg::PH_IDLE;
  logic [4:0]      sq_half    = '0;
  logic [15:0]     sq_frame   = '0;
  logic [7:0]      sq_rx      = '0;
  logic [7:0]      sq_ticks   = '0;
  logic [1:0]      sq_op      = tws_pkg::OP_REG_WR;
  logic            sq_rx_done = 1'b0;

  tws_pkg::out_item_t pin_levels_q[$];
  step_row_t          stim_plan[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned ticks_sent = 0;
  int unsigned words_checked = 0;
  int unsigned n_reg_wr = 0, n_reg_rd = 0, n_fifo = 0, n_rd_done = 0;
  bit          stall_seen = 1'b0;
  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;
  bit          long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One tick of the pin sequencer: returns the pin levels and advances the mirror
  function automatic tws_pkg::out_item_t sequencer_tick(input tws_pkg::in_item_t w);
    tws_pkg::out_item_t pins;
    int unsigned        h;
    int unsigned        stage_len;
    logic [4:0]         last_half;
    logic [3:0]         bit_pos;
    h = (half_ticks_cfg == 8'd0) ? 1 : half_ticks_cfg;
    pins = '0;
    pins.reg_select_n  = 1'b1;
    pins.fifo_select_n = 1'b1;
    pins.sdio_drive    = 1'b1;
    pins.read_valid    = sq_rx_done;
    sq_rx_done = 1'b0;

    // start only from idle; the reserved opcode is dropped
    if (sq_phase == tws_pkg::PH_IDLE && w.cmd_valid && w.opcode != tws_pkg::OP_RESERVED) begin
      sq_op = w.opcode;
      case (w.opcode)
        tws_pkg::OP_REG_WR: begin
          sq_frame = {1'b0, w.reg_address, w.write_byte};
          n_reg_wr++;
        end
        tws_pkg::OP_REG_RD: begin
          sq_frame = {tws_pkg::READ_FLAG | {1'b0, w.reg_address}, 8'h00};
          n_reg_rd++;
        end
        default: begin
          sq_frame = {w.write_byte, 8'h00};
          n_fifo++;
        end
      endcase
      sq_phase = tws_pkg::PH_SHIFT;
      sq_half  = '0;
      sq_ticks = '0;
    end

    if (sq_phase != tws_pkg::PH_IDLE) begin
      pins.busy_res = 1'b1;
      if (sq_op == tws_pkg::OP_FIFO_WR) pins.fifo_select_n = 1'b0;
      else pins.reg_select_n = 1'b0;
      if (sq_phase == tws_pkg::PH_RELEASE) pins.fifo_select_n = 1'b1;
    end

    // drive or sample the data line; reads sample at the end of each high half
    if (sq_phase == tws_pkg::PH_SHIFT) begin
      pins.serial_clock = sq_half[0];
      if (sq_op == tws_pkg::OP_REG_RD && sq_half >= 5'd16) begin
        pins.sdio_drive = 1'b0;
        if (sq_half[0] && sq_ticks + 1 >= h) sq_rx = {sq_rx[6:0], w.sdio_in};
      end else begin
        bit_pos = 4'd15 - sq_half[4:1];
        pins.sdio_out = sq_frame[bit_pos];
      end
    end

    // advance the half-bit and gap counters
    if (sq_phase == tws_pkg::PH_SHIFT) begin
      if (sq_ticks + 1 >= h) begin
        sq_ticks = '0;
        last_half = (sq_op == tws_pkg::OP_FIFO_WR) ? tws_pkg::LAST_HALF_FIFO
                                                   : tws_pkg::LAST_HALF_REG;
        if (sq_half >= last_half) begin
          sq_half = '0;
          if (sq_op == tws_pkg::OP_REG_RD) begin
            sq_phase = tws_pkg::PH_IDLE;
            sq_rx_done = 1'b1;
            n_rd_done++;
          end else if (sq_op == tws_pkg::OP_FIFO_WR && gap_ticks_cfg == 8'd0) begin
            sq_phase = tws_pkg::PH_IDLE;
          end else begin
            sq_phase = tws_pkg::PH_HOLD;
          end
        end else begin
          sq_half = sq_half + 5'd1;
        end
      end else begin
        sq_ticks = sq_ticks + 8'd1;
      end
    end else if (sq_phase == tws_pkg::PH_HOLD || sq_phase == tws_pkg::PH_RELEASE) begin
      stage_len = (sq_op == tws_pkg::OP_FIFO_WR) ? gap_ticks_cfg : h;
      if (sq_ticks + 1 >= stage_len) begin
        sq_ticks = '0;
        if (sq_phase == tws_pkg::PH_HOLD && sq_op == tws_pkg::OP_FIFO_WR &&
            gap_ticks_cfg != 8'd0) begin
          sq_phase = tws_pkg::PH_RELEASE;
        end else begin
          sq_phase = tws_pkg::PH_IDLE;
          sq_half  = '0;
        end
      end else begin
        sq_ticks = sq_ticks + 8'd1;
      end
    end

    pins.read_byte = sq_rx;
    return pins;
  endfunction

  function automatic tws_pkg::out_item_t pins_of(input logic rsel, input logic fsel,
                                                 input logic sclk, input logic dout,
                                                 input logic drive, input logic busy,
                                                 input logic [7:0] rbyte,
                                                 input logic rvalid);
    tws_pkg::out_item_t p;
    p.reg_select_n  = rsel;
    p.fifo_select_n = fsel;
    p.serial_clock  = sclk;
    p.sdio_out      = dout;
    p.sdio_drive    = drive;
    p.busy_res      = busy;
    p.read_byte     = rbyte;
    p.read_valid    = rvalid;
    return p;
  endfunction

  function automatic step_row_t word_row(input logic cv, input logic [1:0] op,
                                         input logic [6:0] addr, input logic [7:0] wbyte,
                                         input logic sdio, input int unsigned count,
                                         input bit typed, input tws_pkg::out_item_t pins);
    step_row_t r;
    r.kind    = ROW_WORD;
    r.cfg_idx = tws_pkg::CFG_IDX_HALF;
    r.cfg_val = 8'd0;
    r.word    = '{cmd_valid: cv, opcode: op, reg_address: addr, write_byte: wbyte,
                  sdio_in: sdio};
    r.count   = count;
    r.typed   = typed;
    r.pins    = pins;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input logic idx, input logic [7:0] val);
    step_row_t r;
    r = word_row(1'b0, tws_pkg::OP_REG_WR, 7'd0, 8'd0, 1'b0, 0, 1'b0, '0);
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic int unsigned draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed traffic: commands from idle, quiet ticks while busy,
  // with the odd command offered mid-transfer and the odd reserved opcode
  function automatic tws_pkg::in_item_t random_tick();
    tws_pkg::in_item_t w;
    logic [7:0]        a;
    a = pick_byte();
    w.reg_address = a[6:0];
    w.write_byte  = pick_byte();
    w.sdio_in     = 1'($urandom_range(0, 1));
    w.opcode      = ($urandom_range(0, 11) == 0) ? tws_pkg::OP_RESERVED
                                                 : 2'($urandom_range(0, 2));
    if (sq_phase == tws_pkg::PH_IDLE) w.cmd_valid = ($urandom_range(0, 9) < 7);
    else w.cmd_valid = ($urandom_range(0, 19) == 0);
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] word %0d: %s got %h want %h", $realtime, words_checked, what, got, want);
  endtask

  task automatic check_word(input tws_pkg::out_item_t got);
    tws_pkg::out_item_t want;
    if (pin_levels_q.size() == 0) begin
      report_mismatch("result word with nothing pending", got.read_byte, 8'h00);
    end else begin
      want = pin_levels_q.pop_front();
      if (got.reg_select_n !== want.reg_select_n)
        report_mismatch("reg_select_n", 8'(got.reg_select_n), 8'(want.reg_select_n));
      if (got.fifo_select_n !== want.fifo_select_n)
        report_mismatch("fifo_select_n", 8'(got.fifo_select_n), 8'(want.fifo_select_n));
      if (got.serial_clock !== want.serial_clock)
        report_mismatch("serial_clock", 8'(got.serial_clock), 8'(want.serial_clock));
      if (got.sdio_out !== want.sdio_out)
        report_mismatch("sdio_out", 8'(got.sdio_out), 8'(want.sdio_out));
      if (got.sdio_drive !== want.sdio_drive)
        report_mismatch("sdio_drive", 8'(got.sdio_drive), 8'(want.sdio_drive));
      if (got.busy_res !== want.busy_res)
        report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      if (got.read_byte !== want.read_byte)
        report_mismatch("read_byte", got.read_byte, want.read_byte);
      if (got.read_valid !== want.read_valid)
        report_mismatch("read_valid", 8'(got.read_valid), 8'(want.read_valid));
    end
    words_checked++;
  endtask

  // Offer one tick word, hold it until taken, then record its pin levels
  task automatic push_word(input tws_pkg::in_item_t w, input bit typed,
                           input tws_pkg::out_item_t typed_pins);
    int unsigned        gap;
    tws_pkg::out_item_t predicted;
    gap = draw_gap(sender_quiet);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (in_full) begin
      stall_seen = 1'b1;
      @(posedge clk);
    end
    predicted = sequencer_tick(w);
    pin_levels_q.push_back(typed ? typed_pins : predicted);
    ticks_sent++;
  endtask

  // Drain the pipeline, let it settle, then write one register
  task automatic write_reg(input logic idx, input logic [7:0] val);
    in_push <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tws_pkg::CFG_IDX_HALF) half_ticks_cfg = val;
    else gap_ticks_cfg = val;
  endtask

  // Result side: random pops, one long hold-off on request
  initial begin : result_side
    int unsigned gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(receiver_quiet);
      if (gap != 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      check_word(out_item);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words pending", cycles, pin_levels_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    tws_pkg::out_item_t idle_pins;
    logic [7:0]         half_plan [0:7];
    logic [7:0]         gap_plan [0:7];
    int unsigned        half_fifo_ticks;

    idle_pins = pins_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    // first FIFO bit at the widest half period and part of the second
    half_fifo_ticks = 2 * 255 + 50;

    // Directed: idle levels, reserved opcode, extreme frames, busy commands,
    // read turnaround and completion, zero gap, zero and widest half period
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b1, 3, 1'b1,
                                 idle_pins));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_RESERVED, 7'h7f, 8'hff, 1'b1, 4, 1'b1,
                                 idle_pins));
    stim_plan.push_back(cfg_row(tws_pkg::CFG_IDX_HALF, 8'd1));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_REG_WR, 7'h7f, 8'hff, 1'b0, 1, 1'b1,
                                 pins_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0)));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b1, 40, 1'b0, '0));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0, 1, 1'b1,
                                 pins_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0)));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_FIFO_WR, 7'h2a, 8'h5a, 1'b1, 20, 1'b0,
                                 '0));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0, 20, 1'b0, '0));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_REG_RD, 7'h7f, 8'h00, 1'b1, 1, 1'b1,
                                 pins_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0)));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b1, 40, 1'b0, '0));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_REG_RD, 7'h00, 8'hff, 1'b0, 1, 1'b1,
                                 pins_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'hff, 1'b0)));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0, 40, 1'b0, '0));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_FIFO_WR, 7'h00, 8'hff, 1'b0, 1, 1'b1,
                                 pins_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0)));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b1, 50, 1'b0, '0));
    stim_plan.push_back(cfg_row(tws_pkg::CFG_IDX_GAP, 8'd0));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_FIFO_WR, 7'h7f, 8'h00, 1'b1, 1, 1'b1,
                                 pins_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0)));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0, 20, 1'b0, '0));
    stim_plan.push_back(cfg_row(tws_pkg::CFG_IDX_HALF, 8'd0));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_REG_RD, 7'h55, 8'haa, 1'b1, 1, 1'b0, '0));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0, 17, 1'b0, '0));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b1, 20, 1'b0, '0));
    stim_plan.push_back(cfg_row(tws_pkg::CFG_IDX_HALF, 8'd255));
    stim_plan.push_back(cfg_row(tws_pkg::CFG_IDX_GAP, 8'd255));
    stim_plan.push_back(word_row(1'b1, tws_pkg::OP_FIFO_WR, 7'h00, 8'ha5, 1'b0, 1, 1'b0, '0));
    stim_plan.push_back(word_row(1'b0, tws_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b1,
                                 half_fifo_ticks, 1'b0, '0));

    half_plan = '{8'd1, 8'd0, 8'd2, 8'd1, 8'd3, 8'd2, 8'd1, 8'd2};
    gap_plan  = '{8'd0, 8'd7, 8'd1, 8'd3, 8'd2, 8'd0, 8'd4, 8'd10};

    // hold reset low, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (stim_plan[i]) begin
      if (stim_plan[i].kind == ROW_CFG) begin
        write_reg(stim_plan[i].cfg_idx, stim_plan[i].cfg_val);
      end else begin
        for (int unsigned k = 0; k < stim_plan[i].count; k++)
          push_word(stim_plan[i].word, stim_plan[i].typed && k == 0, stim_plan[i].pins);
      end
    end

    // random phases, each under its own register setting; transfers may span phases
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(tws_pkg::CFG_IDX_HALF, half_plan[ph]);
      write_reg(tws_pkg::CFG_IDX_GAP, gap_plan[ph]);
      sender_quiet   = (ph == 0) || ($urandom_range(0, 3) == 0);
      receiver_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 2 && n == 40) begin
          sender_quiet  = 1'b1;
          long_hold_req = 1'b1;
        end
        push_word(random_tick(), 1'b0, '0);
      end
    end

    // drop push and wait for the last words to come out
    in_push <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("%0d ticks driven, %0d result words checked in %0d cycles", ticks_sent,
             words_checked, cycles);
    $display("transfers: %0d register writes, %0d reads (%0d completed), %0d FIFO bytes;%s",
             n_reg_wr, n_reg_rd, n_rd_done, n_fifo,
             stall_seen ? " input back-pressure seen" : " no input back-pressure");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
